[hdl/lrusi_pkg.sv]
// Shared constants, codes and control types for the LRU scheduled insertion block.
`default_nettype none

package lrusi_pkg;

  // Fixed field widths of the access and result items.
  localparam int unsigned OPCODE_W  = 2;
  localparam int unsigned SET_IDX_W = 6;
  localparam int unsigned WAY_IDX_W = 3;
  localparam int unsigned AGE_OUT_W = 3;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_SCHED_LEN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MRU_PCT   = 1'd1;

  localparam logic [CFG_DATA_W-1:0] SCHED_LEN_RST = 7'd1;
  localparam logic [CFG_DATA_W-1:0] MRU_PCT_RST   = 7'd0;

  // Opcodes.
  localparam logic [OPCODE_W-1:0] OP_HIT   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_FILL  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_QUERY = 2'd2;

  // Division by 100 of a product below 2^14: floor(x * 41944 / 2^22) is exact.
  localparam int unsigned     PROD_W      = 2 * CFG_DATA_W;
  localparam int unsigned     RECIP_W     = 16;
  localparam logic [RECIP_W-1:0] RECIP_100 = 16'd41944;
  localparam int unsigned     RECIP_SHIFT = 22;
  localparam int unsigned     MCOUNT_W    = 8;

  // Default sizes.
  localparam int unsigned NUM_WAYS_DEF     = 8;
  localparam int unsigned NUM_SETS_DEF     = 64;
  localparam int unsigned MAX_SCHEDULE_DEF = 64;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_wr;  // write the reset row during the clearing pass
    logic load;    // capture an accepted item and read its set
    logic exec;    // update the set, write it back and register the result
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;  // the clearing pass is at its last set
  } dp_status_t;

endpackage

`default_nettype wire

[hdl/lru_scheduled_insertion_replacement.sv]
// Top level of the per-set LRU age table with scheduled MRU/LRU insertion.
`default_nettype none

// The block keeps one LRU age per way for every set of a set-associative cache.
// Requests enter on start with opcode, set_index and way_index; an item is
// accepted at a rising edge where start is high and busy is low. A hit moves
// the way to MRU, a fill inserts at MRU or LRU according to a round-robin
// schedule, and a victim query returns the way whose age is zero.
// Every accepted item produces exactly one result: victim_way_o, new_age_o and
// inserted_mru_o are valid in the single cycle in which done_o is high. done_o
// rises at the edge after the accepting edge. The receiver cannot stall, so
// it takes the result while done_o is high.
// An item is handled in two steps: the load step reads the set's row from the
// single-port age memory and the execute step updates it and writes it back.
// busy is high during the execute step, so no item is taken while one executes.
// After reset the block runs a clearing pass that writes the initial ages
// (way i holds age i) into every set; busy stays high for that time.
// Configuration writes on cfg_we_i/cfg_idx_i/cfg_data_i are taken
// at any edge, also during the clearing pass, and should be made while the
// block is idle; an item accepted at any later edge uses the new values.
module lru_scheduled_insertion_replacement #(
  parameter int unsigned NUM_WAYS     = lrusi_pkg::NUM_WAYS_DEF,
  parameter int unsigned NUM_SETS     = lrusi_pkg::NUM_SETS_DEF,
  parameter int unsigned MAX_SCHEDULE = lrusi_pkg::MAX_SCHEDULE_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [lrusi_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [lrusi_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [lrusi_pkg::OPCODE_W-1:0]   opcode_i,
  input  wire logic [lrusi_pkg::SET_IDX_W-1:0]  set_index_i,
  input  wire logic [lrusi_pkg::WAY_IDX_W-1:0]  way_index_i,
  output logic                                  done_o,
  output logic [lrusi_pkg::WAY_IDX_W-1:0]       victim_way_o,
  output logic [lrusi_pkg::AGE_OUT_W-1:0]       new_age_o,
  output logic                                  inserted_mru_o
);
  import lrusi_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencing: clearing pass, then idle and execute for each item.
  lrusi_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  // Age memory, update logic, insertion schedule and result registers.
  lrusi_dp #(
    .NUM_WAYS     (NUM_WAYS),
    .NUM_SETS     (NUM_SETS),
    .MAX_SCHEDULE (MAX_SCHEDULE)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .opcode_i       (opcode_i),
    .set_index_i    (set_index_i),
    .way_index_i    (way_index_i),
    .done_o         (done_o),
    .victim_way_o   (victim_way_o),
    .new_age_o      (new_age_o),
    .inserted_mru_o (inserted_mru_o)
  );

  // Every accepted item yields its result on done_o.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 done_o)
    else $error("accepted item produced no result");

  // Results never come in consecutive cycles.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  // The block is idle while a result is shown, and no write comes from an idle block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (!busy && !cmd.exec && !cmd.clr_wr))
    else $error("result shown while the block is busy");

endmodule

`default_nettype wire

[hdl/lrusi_ctrl.sv]
// Controller state machine: clearing pass, idle and execute states.
`default_nettype none

module lrusi_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start,
  input  wire lrusi_pkg::dp_status_t  status_i,
  output lrusi_pkg::ctrl_cmd_t        cmd_o,
  output logic                        busy
);
  import lrusi_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (status_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy         = (state_q != S_IDLE);
  assign cmd_o.clr_wr = (state_q == S_CLEAR);
  assign cmd_o.load   = (state_q == S_IDLE) && start;
  assign cmd_o.exec   = (state_q == S_EXEC);

endmodule

`default_nettype wire

[hdl/lrusi_dp.sv]
// Datapath: age memory, age update logic, insertion schedule and result registers.
`default_nettype none

module lrusi_dp #(
  parameter int unsigned NUM_WAYS     = lrusi_pkg::NUM_WAYS_DEF,
  parameter int unsigned NUM_SETS     = lrusi_pkg::NUM_SETS_DEF,
  parameter int unsigned MAX_SCHEDULE = lrusi_pkg::MAX_SCHEDULE_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire lrusi_pkg::ctrl_cmd_t               cmd_i,
  output lrusi_pkg::dp_status_t                   status_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [lrusi_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [lrusi_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic [lrusi_pkg::OPCODE_W-1:0]     opcode_i,
  input  wire logic [lrusi_pkg::SET_IDX_W-1:0]    set_index_i,
  input  wire logic [lrusi_pkg::WAY_IDX_W-1:0]    way_index_i,
  output logic                                    done_o,
  output logic [lrusi_pkg::WAY_IDX_W-1:0]         victim_way_o,
  output logic [lrusi_pkg::AGE_OUT_W-1:0]         new_age_o,
  output logic                                    inserted_mru_o
);
  import lrusi_pkg::*;

  localparam int unsigned AW     = $clog2(NUM_WAYS);
  localparam int unsigned ROW_W  = NUM_WAYS * AW;
  localparam int unsigned SW     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int unsigned PW     = (MAX_SCHEDULE > 1) ? $clog2(MAX_SCHEDULE) : 1;
  localparam int unsigned CMPW   = ((PW > CFG_DATA_W) ? PW : CFG_DATA_W) + 1;
  localparam int unsigned IDX_IN = 1 << SET_IDX_W;
  localparam int unsigned EXT_W  = 5;

  localparam logic [AW-1:0]        MRU_AGE     = AW'(NUM_WAYS - 1);
  localparam logic [AGE_OUT_W-1:0] MRU_AGE_OUT = AGE_OUT_W'((NUM_WAYS - 1) % 8);
  localparam logic [SW-1:0]        LAST_SET    = SW'(NUM_SETS - 1);

  typedef logic [IDX_IN-1:0][SW-1:0] wrap_tbl_t;

  // Set index wrapped into the set count, one entry per input code.
  function automatic wrap_tbl_t build_wrap();
    wrap_tbl_t t;
    for (int i = 0; i < IDX_IN; i++) begin
      t[i] = SW'(i % NUM_SETS);
    end
    return t;
  endfunction

  function automatic logic [ROW_W-1:0] reset_row();
    logic [ROW_W-1:0] r;
    for (int i = 0; i < NUM_WAYS; i++) begin
      r[i*AW +: AW] = AW'(i);
    end
    return r;
  endfunction

  localparam wrap_tbl_t        WRAP_TBL = build_wrap();
  localparam logic [ROW_W-1:0] RST_ROW  = reset_row();

  // Configuration and insertion schedule.
  logic [CFG_DATA_W-1:0] sched_len_q, mru_pct_q;
  logic [CFG_DATA_W-1:0] eff_len;
  logic [PROD_W-1:0]     prod_q;
  logic [PROD_W+RECIP_W-1:0] recip_prod;
  logic [MCOUNT_W-1:0]   mcount;
  logic [PW-1:0]         ptr_q, ptr_d;
  logic [CMPW-1:0]       ptr_ext, ptr_inc, len_ext, mcount_ext;
  logic                  fill_mru;

  always_comb begin
    if (sched_len_q == '0) begin
      eff_len = CFG_DATA_W'(1);
    end else if ((CMPW + 1)'(sched_len_q) > (CMPW + 1)'(MAX_SCHEDULE)) begin
      eff_len = CFG_DATA_W'(MAX_SCHEDULE);
    end else begin
      eff_len = sched_len_q;
    end
  end

  assign recip_prod = (PROD_W + RECIP_W)'(prod_q) * (PROD_W + RECIP_W)'(RECIP_100);
  assign mcount     = MCOUNT_W'(recip_prod >> RECIP_SHIFT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sched_len_q <= SCHED_LEN_RST;
      mru_pct_q   <= MRU_PCT_RST;
      prod_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_SCHED_LEN: sched_len_q <= cfg_data_i;
          REG_MRU_PCT:   mru_pct_q   <= cfg_data_i;
          default:       sched_len_q <= sched_len_q;
        endcase
      end
      prod_q <= PROD_W'(eff_len) * PROD_W'(mru_pct_q);
    end
  end

  assign ptr_ext    = CMPW'(ptr_q);
  assign ptr_inc    = ptr_ext + CMPW'(1);
  assign len_ext    = CMPW'(eff_len);
  assign mcount_ext = CMPW'(mcount);
  assign fill_mru   = (ptr_ext < mcount_ext) && (ptr_ext < len_ext);
  assign ptr_d      = (ptr_inc >= len_ext) ? '0 : PW'(ptr_inc);

  // Item registers and age memory.
  logic [OPCODE_W-1:0]  op_q;
  logic [SW-1:0]        set_q;
  logic [WAY_IDX_W-1:0] way_q;
  logic [ROW_W-1:0]     rd_row_q;
  logic [ROW_W-1:0]     age_mem_q [NUM_SETS];
  logic [SW-1:0]        clr_cnt_q;
  logic [SW-1:0]        rd_addr, wr_addr;
  logic [ROW_W-1:0]     wr_row;
  logic                 wr_en;

  assign rd_addr = WRAP_TBL[set_index_i];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= opcode_i;
      set_q    <= rd_addr;
      way_q    <= way_index_i;
      rd_row_q <= age_mem_q[rd_addr];
    end
    if (wr_en) begin
      age_mem_q[wr_addr] <= wr_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_cnt_q <= clr_cnt_q + SW'(1);
    end
  end

  assign status_o.clr_last = (clr_cnt_q == LAST_SET);

  // Age update for the addressed set.
  logic [AW-1:0]           ages     [NUM_WAYS];
  logic [ROW_W-1:0]        mru_row, lru_row, upd_row;
  logic [AW-1:0]           old_age;
  logic [AW-1:0]           victim;
  logic [EXT_W-1:0]        way_ext, victim_ext;
  logic [AW-1:0]           way_sel;
  logic                    way_ok;
  logic [WAY_IDX_W-1:0]    victim_d;
  logic [AGE_OUT_W-1:0]    age_d;
  logic                    ins_d;

  assign way_ext    = EXT_W'(way_q);
  assign way_sel    = way_ext[AW-1:0];
  assign way_ok     = (way_ext < EXT_W'(NUM_WAYS));
  assign old_age    = ages[way_sel];
  assign victim_ext = {{(EXT_W - AW){1'b0}}, victim};

  always_comb begin
    victim = '0;
    for (int i = 0; i < NUM_WAYS; i++) begin
      ages[i] = rd_row_q[i*AW +: AW];
    end
    for (int i = 0; i < NUM_WAYS; i++) begin
      if (ages[i] == '0) begin
        victim = AW'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_WAYS; i++) begin
      if (AW'(i) == way_sel) begin
        mru_row[i*AW +: AW] = MRU_AGE;
        lru_row[i*AW +: AW] = '0;
      end else begin
        mru_row[i*AW +: AW] = (ages[i] > old_age) ? ages[i] - AW'(1) : ages[i];
        lru_row[i*AW +: AW] = (ages[i] < old_age) ? ages[i] + AW'(1) : ages[i];
      end
    end
  end

  always_comb begin
    upd_row  = rd_row_q;
    victim_d = '0;
    age_d    = '0;
    ins_d    = 1'b0;
    unique case (op_q)
      OP_HIT: begin
        if (way_ok) begin
          upd_row = mru_row;
          age_d   = MRU_AGE_OUT;
        end
      end
      OP_FILL: begin
        if (way_ok) begin
          ins_d   = fill_mru;
          upd_row = fill_mru ? mru_row : lru_row;
          age_d   = fill_mru ? MRU_AGE_OUT : '0;
        end
      end
      OP_QUERY: begin
        victim_d = victim_ext[WAY_IDX_W-1:0];
      end
      default: begin
        upd_row = rd_row_q;
      end
    endcase
  end

  assign wr_en   = cmd_i.clr_wr || cmd_i.exec;
  assign wr_addr = cmd_i.clr_wr ? clr_cnt_q : set_q;
  assign wr_row  = cmd_i.clr_wr ? RST_ROW : upd_row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q          <= '0;
      done_o         <= 1'b0;
      victim_way_o   <= '0;
      new_age_o      <= '0;
      inserted_mru_o <= 1'b0;
    end else begin
      done_o <= cmd_i.exec;
      if (cmd_i.exec) begin
        victim_way_o   <= victim_d;
        new_age_o      <= age_d;
        inserted_mru_o <= ins_d;
        if (op_q == OP_FILL && way_ok) begin
          ptr_q <= ptr_d;
        end
      end
    end
  end

endmodule

`default_nettype wire
